@@ rtl/trnr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trnr_pkg
// Shared types and codes of the tristate net resolver.
// ----------------------------------------------------------------------------
package trnr_pkg;

	localparam int PIN_W  = 8;
	localparam int NODE_W = 6;
	localparam int CNT_W  = 9;

	typedef enum logic [2:0] {
		ACT_WRITE   = 3'd0,
		ACT_STEP    = 3'd1,
		ACT_READ    = 3'd2,
		ACT_MAP     = 3'd3,
		ACT_DEFAULT = 3'd4,
		ACT_INIT    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_CHANGE = 2'd1,
		KIND_STABLE = 2'd2
	} kind_t;

	localparam logic [1:0] LV_FALSE = 2'd0;
	localparam logic [1:0] LV_UNDEF = 2'd2;
	localparam logic [1:0] LV_ERROR = 2'd3;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [1:0]        level;
		logic              driving;
	} pin_rec_t;

	typedef struct packed {
		logic [1:0]       dflt;
		logic [1:0]       pend;
		logic [1:0]       settled;
		logic             dirty;
		logic [CNT_W-1:0] cnt;
		logic [PIN_W-1:0] drv_xor;
	} node_rec_t;

endpackage
`default_nettype wire

@@ rtl/trnr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trnr_if
// Request and response channels of the tristate net resolver.
// ----------------------------------------------------------------------------
interface trnr_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] pin;
	logic [5:0] node;
	logic [1:0] level;

	modport source (output valid, action, pin, node, level, input ready);
	modport sink (input valid, action, pin, node, level, output ready);
endinterface

interface trnr_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [5:0] node_id;
	logic [1:0] node_level;
	logic       changed_before;
	logic       last;

	modport source (output valid, kind, node_id, node_level, changed_before, last,
		input ready);
	modport sink (input valid, kind, node_id, node_level, changed_before, last,
		output ready);
endinterface
`default_nettype wire

@@ rtl/trnr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trnr_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module trnr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/trnr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trnr_ctrl
// Sequencer: read-modify-write of pin and node records, dirty queue, step end.
// ----------------------------------------------------------------------------
module trnr_ctrl #(
	parameter int PIN_COUNT = 256,
	parameter int NUM_NODES = 64,
	parameter int TIME_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	trnr_req_if.sink   req,
	trnr_rsp_if.source rsp,
	output logic                                pin_we,
	output logic [$clog2(PIN_COUNT)-1:0]        pin_waddr,
	output logic [$bits(trnr_pkg::pin_rec_t)-1:0] pin_wdata,
	output logic [$clog2(PIN_COUNT)-1:0]        pin_raddr,
	input  wire logic [$bits(trnr_pkg::pin_rec_t)-1:0] pin_rdata,
	output logic                                node_we,
	output logic [$clog2(NUM_NODES)-1:0]        node_waddr,
	output logic [$bits(trnr_pkg::node_rec_t)+TIME_BITS-1:0] node_wdata,
	output logic [$clog2(NUM_NODES)-1:0]        node_raddr,
	input  wire logic [$bits(trnr_pkg::node_rec_t)+TIME_BITS-1:0] node_rdata
);

	localparam int PW    = $clog2(PIN_COUNT);
	localparam int NW    = $clog2(NUM_NODES);
	localparam int RW    = $bits(trnr_pkg::node_rec_t);
	localparam int CLR_N = (PIN_COUNT > NUM_NODES) ? PIN_COUNT : NUM_NODES;
	localparam int CW    = $clog2(CLR_N);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PIN_W, S_PIN_D, S_NODE_W, S_NODE_D, S_MAP_W, S_MAP_D,
		S_STEP, S_STEP_Q, S_STEP_NW, S_STEP_ND, S_STEP_PW, S_STEP_PD, S_STEP_FIN
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            clr_q;
	logic [2:0]               act_q;
	logic [trnr_pkg::PIN_W-1:0]  pin_q;
	logic [trnr_pkg::NODE_W-1:0] nd_q;
	logic [1:0]               lv_q;
	logic                     pin_ok_q;
	trnr_pkg::pin_rec_t       pin_rec_q;
	logic [TIME_BITS-1:0]     sim_time_q;
	logic [NW:0]              dcnt_q;
	logic [NW:0]              idx_q;
	logic [trnr_pkg::NODE_W-1:0] n_q;
	logic                     hold_v_q;
	logic [trnr_pkg::NODE_W-1:0] hold_id_q;
	logic [1:0]               hold_lv_q;

	logic                     ov_q;
	logic [1:0]               okind_q;
	logic [5:0]               oid_q;
	logic [1:0]               olv_q;
	logic                     och_q;
	logic                     olast_q;

	logic                     pin_we_q, node_we_q;
	logic [PW-1:0]            pin_waddr_q, pin_raddr_q;
	trnr_pkg::pin_rec_t       pin_wdata_q;
	logic [NW-1:0]            node_waddr_q, node_raddr_q;
	logic [RW+TIME_BITS-1:0]  node_wdata_q;

	logic [trnr_pkg::NODE_W-1:0] dq [NUM_NODES];
	logic                     dq_we_q;
	logic [NW-1:0]            dq_waddr_q;
	logic [trnr_pkg::NODE_W-1:0] dq_wdata_q;
	logic [trnr_pkg::NODE_W-1:0] qrd_q;

	trnr_pkg::pin_rec_t       pin_rd, pin_upd;
	trnr_pkg::node_rec_t      node_rd, node_upd, node_add, node_res;
	logic [TIME_BITS-1:0]     node_time, time_upd, time_res;
	logic [1:0]               res_lv;
	logic                     changed;
	logic                     out_free;
	logic                     req_pin_ok, req_nd_ok;

	assign pin_rd    = trnr_pkg::pin_rec_t'(pin_rdata);
	assign node_rd   = trnr_pkg::node_rec_t'(node_rdata[RW-1:0]);
	assign node_time = node_rdata[RW+TIME_BITS-1:RW];
	assign out_free  = !ov_q || rsp.ready;
	assign req_pin_ok = int'(req.pin) < PIN_COUNT;
	assign req_nd_ok  = int'(req.node) < NUM_NODES;

	// record updates for the single-item actions
	always_comb begin
		pin_upd  = pin_rec_q;
		node_upd = node_rd;
		time_upd = node_time;
		unique case (act_q)
			trnr_pkg::ACT_WRITE: begin
				pin_upd.level = lv_q;
				node_upd.dirty = 1'b1;
				if (lv_q == trnr_pkg::LV_UNDEF) begin
					if (pin_rec_q.driving) begin
						pin_upd.driving = 1'b0;
						if (node_rd.cnt != '0) begin
							node_upd.cnt = node_rd.cnt - 1'b1;
						end
						node_upd.drv_xor = node_rd.drv_xor ^ pin_q;
					end
				end else begin
					node_upd.pend = lv_q;
					if (!pin_rec_q.driving) begin
						pin_upd.driving = 1'b1;
						node_upd.cnt = node_rd.cnt + 1'b1;
						node_upd.drv_xor = node_rd.drv_xor ^ pin_q;
					end
				end
			end
			trnr_pkg::ACT_INIT: begin
				pin_upd.level    = lv_q;
				node_upd.pend    = lv_q;
				node_upd.settled = lv_q;
				time_upd         = sim_time_q;
			end
			trnr_pkg::ACT_DEFAULT: begin
				node_upd.dflt = lv_q;
			end
			trnr_pkg::ACT_MAP: begin
				pin_upd.node = nd_q;
				if (node_rd.cnt != '0) begin
					node_upd.cnt = node_rd.cnt - 1'b1;
				end
				node_upd.drv_xor = node_rd.drv_xor ^ pin_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		node_add = node_rd;
		node_add.cnt = node_rd.cnt + 1'b1;
		node_add.drv_xor = node_rd.drv_xor ^ pin_q;
	end

	// step-end resolution of one node
	always_comb begin
		if (node_rd.cnt == '0) begin
			res_lv = node_rd.dflt;
		end else if (node_rd.cnt == trnr_pkg::CNT_W'(1)) begin
			res_lv = (int'(node_rd.drv_xor) < PIN_COUNT) ? pin_rd.level : trnr_pkg::LV_ERROR;
		end else begin
			res_lv = trnr_pkg::LV_ERROR;
		end
		changed  = node_rd.settled != res_lv;
		node_res = node_rd;
		node_res.pend  = res_lv;
		node_res.dirty = 1'b0;
		node_res.settled = res_lv;
		time_res = changed ? sim_time_q : node_time;
	end

	assign req.ready = state_q == S_IDLE;

	assign rsp.valid          = ov_q;
	assign rsp.kind           = okind_q;
	assign rsp.node_id        = oid_q;
	assign rsp.node_level     = olv_q;
	assign rsp.changed_before = och_q;
	assign rsp.last           = olast_q;

	assign pin_we     = pin_we_q;
	assign pin_waddr  = pin_waddr_q;
	assign pin_wdata  = pin_wdata_q;
	assign pin_raddr  = pin_raddr_q;
	assign node_we    = node_we_q;
	assign node_waddr = node_waddr_q;
	assign node_wdata = node_wdata_q;
	assign node_raddr = node_raddr_q;

	always_ff @(posedge clk) begin
		if (dq_we_q) begin
			dq[dq_waddr_q] <= dq_wdata_q;
		end
		qrd_q <= dq[idx_q[NW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			sim_time_q <= TIME_BITS'(1);
			dcnt_q     <= '0;
			idx_q      <= '0;
			hold_v_q   <= 1'b0;
			ov_q       <= 1'b0;
			pin_we_q   <= 1'b0;
			node_we_q  <= 1'b0;
			dq_we_q    <= 1'b0;
		end else begin
			pin_we_q  <= 1'b0;
			node_we_q <= 1'b0;
			dq_we_q   <= 1'b0;
			if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					pin_we_q    <= int'(clr_q) < PIN_COUNT;
					pin_waddr_q <= PW'(clr_q);
					pin_wdata_q <= '{node: '0, level: trnr_pkg::LV_UNDEF, driving: 1'b0};
					node_we_q    <= int'(clr_q) < NUM_NODES;
					node_waddr_q <= NW'(clr_q);
					node_wdata_q <= {TIME_BITS'(0), trnr_pkg::LV_UNDEF,
						trnr_pkg::LV_FALSE, trnr_pkg::LV_FALSE, 1'b0,
						trnr_pkg::CNT_W'(0), trnr_pkg::PIN_W'(0)};
					if (clr_q == CW'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						act_q       <= req.action;
						pin_q       <= req.pin;
						nd_q        <= req.node;
						lv_q        <= req.level;
						pin_ok_q    <= req_pin_ok;
						pin_raddr_q <= PW'(req.pin);
						node_raddr_q <= NW'(req.node);
						idx_q       <= '0;
						priority case (req.action)
							trnr_pkg::ACT_READ:    state_q <= S_PIN_W;
							trnr_pkg::ACT_WRITE,
							trnr_pkg::ACT_INIT:    if (req_pin_ok) state_q <= S_PIN_W;
							trnr_pkg::ACT_MAP:     if (req_pin_ok && req_nd_ok) state_q <= S_PIN_W;
							trnr_pkg::ACT_DEFAULT: if (req_nd_ok) state_q <= S_NODE_W;
							trnr_pkg::ACT_STEP:    state_q <= S_STEP;
							default:               state_q <= S_IDLE;
						endcase
					end
				end
				S_PIN_W: state_q <= S_PIN_D;
				S_PIN_D: begin
					pin_rec_q    <= pin_rd;
					node_raddr_q <= NW'(pin_rd.node);
					state_q      <= S_NODE_W;
				end
				S_NODE_W: state_q <= S_NODE_D;
				S_NODE_D: begin
					unique case (act_q)
						trnr_pkg::ACT_READ: begin
							if (out_free) begin
								ov_q    <= 1'b1;
								okind_q <= trnr_pkg::KIND_READ;
								oid_q   <= pin_ok_q ? pin_rec_q.node : '0;
								olv_q   <= pin_ok_q ? node_rd.settled : trnr_pkg::LV_UNDEF;
								och_q   <= pin_ok_q && (node_time == sim_time_q - 1'b1);
								olast_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						trnr_pkg::ACT_WRITE, trnr_pkg::ACT_INIT: begin
							pin_we_q     <= 1'b1;
							pin_waddr_q  <= PW'(pin_q);
							pin_wdata_q  <= pin_upd;
							node_we_q    <= 1'b1;
							node_waddr_q <= NW'(pin_rec_q.node);
							node_wdata_q <= {time_upd, node_upd};
							if (act_q == trnr_pkg::ACT_WRITE && !node_rd.dirty) begin
								dq_we_q    <= 1'b1;
								dq_waddr_q <= NW'(dcnt_q);
								dq_wdata_q <= pin_rec_q.node;
								dcnt_q     <= dcnt_q + 1'b1;
							end
							state_q <= S_IDLE;
						end
						trnr_pkg::ACT_DEFAULT: begin
							node_we_q    <= 1'b1;
							node_waddr_q <= NW'(nd_q);
							node_wdata_q <= {time_upd, node_upd};
							state_q      <= S_IDLE;
						end
						trnr_pkg::ACT_MAP: begin
							pin_we_q    <= 1'b1;
							pin_waddr_q <= PW'(pin_q);
							pin_wdata_q <= pin_upd;
							if (pin_rec_q.driving && pin_rec_q.node != nd_q) begin
								// drop from old node, then fetch the new one
								node_we_q    <= 1'b1;
								node_waddr_q <= NW'(pin_rec_q.node);
								node_wdata_q <= {time_upd, node_upd};
								node_raddr_q <= NW'(nd_q);
								state_q      <= S_MAP_W;
							end else begin
								state_q <= S_IDLE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_MAP_W: state_q <= S_MAP_D;
				S_MAP_D: begin
					node_we_q    <= 1'b1;
					node_waddr_q <= NW'(nd_q);
					node_wdata_q <= {node_time, node_add};
					state_q      <= S_IDLE;
				end
				S_STEP: begin
					state_q <= (idx_q == dcnt_q) ? S_STEP_FIN : S_STEP_Q;
				end
				S_STEP_Q: begin
					n_q          <= qrd_q;
					node_raddr_q <= NW'(qrd_q);
					state_q      <= S_STEP_NW;
				end
				S_STEP_NW: state_q <= S_STEP_ND;
				S_STEP_ND: begin
					pin_raddr_q <= PW'(node_rd.drv_xor);
					state_q     <= S_STEP_PW;
				end
				S_STEP_PW: state_q <= S_STEP_PD;
				S_STEP_PD: begin
					if (!(changed && hold_v_q && !out_free)) begin
						node_we_q    <= 1'b1;
						node_waddr_q <= NW'(n_q);
						node_wdata_q <= {time_res, node_res};
						if (changed) begin
							// a change is held back until the next one shows it was not last
							if (hold_v_q) begin
								ov_q    <= 1'b1;
								okind_q <= trnr_pkg::KIND_CHANGE;
								oid_q   <= hold_id_q;
								olv_q   <= hold_lv_q;
								och_q   <= 1'b0;
								olast_q <= 1'b0;
							end
							hold_v_q  <= 1'b1;
							hold_id_q <= n_q;
							hold_lv_q <= res_lv;
						end
						idx_q   <= idx_q + 1'b1;
						state_q <= S_STEP;
					end
				end
				S_STEP_FIN: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						okind_q <= hold_v_q ? trnr_pkg::KIND_CHANGE : trnr_pkg::KIND_STABLE;
						oid_q   <= hold_v_q ? hold_id_q : '0;
						olv_q   <= hold_v_q ? hold_lv_q : trnr_pkg::LV_FALSE;
						och_q   <= 1'b0;
						olast_q <= 1'b1;
						hold_v_q   <= 1'b0;
						dcnt_q     <= '0;
						idx_q      <= '0;
						sim_time_q <= sim_time_q + 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/tristate_net_resolver_top.sv @@
`default_nettype none
// Write/set-initial/map read the pin record, then its node record, then write back; set-default
// reads only the node record; map may also fetch the new node; read replies after both reads.
// Step end: per dirty node, the queue, node RAM and pin RAM are read in turn, then written.
// One request in flight. Reset: after arst_n rises, a clearing pass over max(PIN_COUNT, NUM_NODES)
// addresses initializes both RAMs; no request is taken until it completes.
// ----------------------------------------------------------------------------
// tristate_net_resolver_top
// Net resolution engine: pin map, driver tracking and step-end resolution.
// ----------------------------------------------------------------------------
module tristate_net_resolver_top #(
	parameter int PIN_COUNT = 256,
	parameter int NUM_NODES = 64,
	parameter int TIME_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	trnr_req_if.sink   req,
	trnr_rsp_if.source rsp
);

	localparam int PW  = $clog2(PIN_COUNT);
	localparam int NW  = $clog2(NUM_NODES);
	localparam int PRW = $bits(trnr_pkg::pin_rec_t);
	localparam int NRW = $bits(trnr_pkg::node_rec_t) + TIME_BITS;

	logic           pin_we, node_we;
	logic [PW-1:0]  pin_waddr, pin_raddr;
	logic [PRW-1:0] pin_wdata, pin_rdata;
	logic [NW-1:0]  node_waddr, node_raddr;
	logic [NRW-1:0] node_wdata, node_rdata;

	trnr_ram #(.DEPTH(PIN_COUNT), .WIDTH(PRW)) u_pin_ram (
		.clk(clk), .we(pin_we), .waddr(pin_waddr), .wdata(pin_wdata),
		.raddr(pin_raddr), .rdata(pin_rdata)
	);

	trnr_ram #(.DEPTH(NUM_NODES), .WIDTH(NRW)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rdata)
	);

	trnr_ctrl #(.PIN_COUNT(PIN_COUNT), .NUM_NODES(NUM_NODES), .TIME_BITS(TIME_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.pin_we(pin_we), .pin_waddr(pin_waddr), .pin_wdata(pin_wdata),
		.pin_raddr(pin_raddr), .pin_rdata(pin_rdata),
		.node_we(node_we), .node_waddr(node_waddr), .node_wdata(node_wdata),
		.node_raddr(node_raddr), .node_rdata(node_rdata)
	);

endmodule
`default_nettype wire

@@ rtl/trnr_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trnr_checker
// Port-level checks on the response channel of the net resolver.
// ----------------------------------------------------------------------------
module trnr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [1:0] rsp_kind,
	input wire logic [5:0] rsp_node_id,
	input wire logic [1:0] rsp_node_level,
	input wire logic       rsp_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_node_id))
		else $error("response changed while stalled");

	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == trnr_pkg::KIND_READ |-> rsp_last)
		else $error("read reply not marked last");

	a_stable_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == trnr_pkg::KIND_STABLE |->
			rsp_last && rsp_node_id == '0 && rsp_node_level == trnr_pkg::LV_FALSE)
		else $error("malformed stable result");

	a_no_after_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last |=> !(rsp_valid && rsp_kind == trnr_pkg::KIND_READ))
		else $error("read reply inside a step-end burst");

endmodule

bind tristate_net_resolver_top trnr_checker u_trnr_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_kind(rsp.kind), .rsp_node_id(rsp.node_id), .rsp_node_level(rsp.node_level),
	.rsp_last(rsp.last)
);
`default_nettype wire

@@ bench/tristate_net_resolver_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tristate_net_resolver_top_test
// Checks pin writes, step-end resolution, reads, mapping, defaults and
// initial values against a behavioral net model, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tristate_net_resolver_top_test;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] node_id;
		logic [1:0] node_level;
		logic       changed_before;
		logic       last;
	} net_rsp_t;

	logic clk;
	logic arst_n;
	int   errors;
	bit   sink_stall_on;

	trnr_req_if req ();
	trnr_rsp_if rsp ();

	tristate_net_resolver_top u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	// net model state
	logic [5:0]  pin_map    [256];
	logic [1:0]  pin_lv     [256];
	bit          pin_drv    [256];
	int unsigned drv_cnt    [64];
	logic [7:0]  drv_xor    [64];
	logic [1:0]  node_dflt  [64];
	logic [1:0]  node_pend  [64];
	logic [1:0]  node_set   [64];
	logic [31:0] node_ctime [64];
	bit          node_mark  [64];
	logic [5:0]  dirty_q    [$];
	logic [31:0] now_step;
	net_rsp_t    expected_rsp [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("[tristate_net_resolver_top] ERROR");
		$finish;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(5, 25);
		return $urandom_range(0, 2);
	endfunction

	function automatic logic [1:0] settle_node(int n);
		if (drv_cnt[n] == 0)
			return node_dflt[n];
		if (drv_cnt[n] == 1)
			return pin_lv[drv_xor[n]];
		return trnr_pkg::LV_ERROR;
	endfunction

	task automatic push_rsp(logic [1:0] k, logic [5:0] n, logic [1:0] lv, logic ch);
		net_rsp_t r;
		r.kind = k;
		r.node_id = n;
		r.node_level = lv;
		r.changed_before = ch;
		r.last = 1'b0;
		expected_rsp.insert(expected_rsp.size(), r);
	endtask

	task automatic predict_net(trnr_pkg::action_t a, logic [7:0] p, logic [5:0] nd,
			logic [1:0] lv);
		int n;
		int cnt;
		case (a)
			trnr_pkg::ACT_WRITE: begin
				n = pin_map[p];
				pin_lv[p] = lv;
				if (!node_mark[n]) begin
					node_mark[n] = 1;
					dirty_q.insert(dirty_q.size(), 6'(n));
				end
				if (lv == trnr_pkg::LV_UNDEF) begin
					if (pin_drv[p]) begin
						pin_drv[p] = 0;
						if (drv_cnt[n] > 0) drv_cnt[n]--;
						drv_xor[n] ^= p;
					end
				end else begin
					node_pend[n] = lv;
					if (!pin_drv[p]) begin
						pin_drv[p] = 1;
						drv_cnt[n]++;
						drv_xor[n] ^= p;
					end
				end
			end
			trnr_pkg::ACT_STEP: begin
				cnt = 0;
				foreach (dirty_q[i]) begin
					n = dirty_q[i];
					node_pend[n] = settle_node(n);
					node_mark[n] = 0;
					if (node_set[n] != node_pend[n]) begin
						node_set[n] = node_pend[n];
						node_ctime[n] = now_step;
						push_rsp(trnr_pkg::KIND_CHANGE, n, node_set[n], 1'b0);
						cnt++;
					end
				end
				dirty_q.delete();
				if (cnt == 0)
					push_rsp(trnr_pkg::KIND_STABLE, 0, 0, 1'b0);
				expected_rsp[$].last = 1'b1;
				now_step = now_step + 1;
			end
			trnr_pkg::ACT_READ: begin
				n = pin_map[p];
				push_rsp(trnr_pkg::KIND_READ, n, node_set[n], node_ctime[n] == now_step - 1);
				expected_rsp[$].last = 1'b1;
			end
			trnr_pkg::ACT_MAP: begin
				n = pin_map[p];
				if (pin_drv[p] && n != nd) begin
					if (drv_cnt[n] > 0) drv_cnt[n]--;
					drv_xor[n] ^= p;
					drv_cnt[nd]++;
					drv_xor[nd] ^= p;
				end
				pin_map[p] = nd;
			end
			trnr_pkg::ACT_DEFAULT: node_dflt[nd] = lv;
			trnr_pkg::ACT_INIT: begin
				n = pin_map[p];
				pin_lv[p] = lv;
				node_pend[n] = lv;
				node_set[n] = lv;
				node_ctime[n] = now_step;
			end
			default: ;
		endcase
	endtask

	// valid drops after each handshake and stays low through a random gap before the next request
	task automatic send_request(logic [2:0] a, logic [7:0] p, logic [5:0] nd, logic [1:0] lv);
		int g;
		g = gap_len();
		repeat (g + 1) @(posedge clk);
		req.valid  <= 1'b1;
		req.action <= a;
		req.pin    <= p;
		req.node   <= nd;
		req.level  <= lv;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_net(trnr_pkg::action_t'(a), p, nd, lv);
		req.valid <= 1'b0;
	endtask

	task automatic drain_expected();
		while (expected_rsp.size() != 0) @(posedge clk);
	endtask

	// response checker
	initial begin
		net_rsp_t e;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t unexpected response kind %0d node %0d", $time,
						rsp.kind, rsp.node_id);
					errors++;
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.kind !== e.kind || rsp.node_id !== e.node_id ||
							rsp.node_level !== e.node_level ||
							rsp.changed_before !== e.changed_before ||
							rsp.last !== e.last) begin
						$display("%0t mismatch exp k%0d n%0d lv%0d ch%0d l%0d act k%0d n%0d lv%0d ch%0d l%0d",
							$time, e.kind, e.node_id, e.node_level, e.changed_before,
							e.last, rsp.kind, rsp.node_id, rsp.node_level,
							rsp.changed_before, rsp.last);
						errors++;
					end
				end
			end
		end
	end

	// sink backpressure
	initial begin
		int g;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_stall_on && $urandom_range(0, 3) == 0) begin
				g = gap_len();
				if (g > 0) begin
					rsp.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			rsp.ready <= 1'b1;
		end
	end

	task automatic test_directed();
		send_request(trnr_pkg::ACT_READ, 8'd0, 0, 0);
		send_request(trnr_pkg::ACT_STEP, 0, 0, 0);
		send_request(trnr_pkg::ACT_DEFAULT, 0, 6'd63, 2'd1);
		send_request(trnr_pkg::ACT_MAP, 8'd255, 6'd63, 0);
		send_request(trnr_pkg::ACT_MAP, 8'd1, 6'd63, 0);
		send_request(trnr_pkg::ACT_WRITE, 8'd255, 0, 2'd0);
		send_request(trnr_pkg::ACT_STEP, 0, 0, 0);
		send_request(trnr_pkg::ACT_WRITE, 8'd1, 0, 2'd1);
		send_request(trnr_pkg::ACT_STEP, 0, 0, 0);
		send_request(trnr_pkg::ACT_READ, 8'd255, 0, 0);
		send_request(trnr_pkg::ACT_WRITE, 8'd1, 0, trnr_pkg::LV_UNDEF);
		send_request(trnr_pkg::ACT_WRITE, 8'd255, 0, trnr_pkg::LV_UNDEF);
		send_request(trnr_pkg::ACT_STEP, 0, 0, 0);
		send_request(trnr_pkg::ACT_MAP, 8'd2, 6'd5, 0);
		send_request(trnr_pkg::ACT_WRITE, 8'd2, 0, trnr_pkg::LV_ERROR);
		send_request(trnr_pkg::ACT_MAP, 8'd2, 6'd0, 0);
		send_request(trnr_pkg::ACT_STEP, 0, 0, 0);
		send_request(trnr_pkg::ACT_INIT, 8'd2, 0, 2'd1);
		send_request(trnr_pkg::ACT_READ, 8'd2, 0, 0);
		send_request(3'd6, 8'd3, 6'd3, 2'd3);
		send_request(3'd7, 8'd3, 6'd3, 2'd3);
		send_request(trnr_pkg::ACT_STEP, 0, 0, 0);
		send_request(trnr_pkg::ACT_READ, 8'd2, 0, 0);
	endtask

	task automatic test_random();
		int r;
		logic [2:0] a;
		for (int i = 0; i < 106; i++) begin
			if (i == 53) drain_expected();
			r = $urandom_range(0, 99);
			if (r < 35) a = trnr_pkg::ACT_WRITE;
			else if (r < 50) a = trnr_pkg::ACT_STEP;
			else if (r < 65) a = trnr_pkg::ACT_READ;
			else if (r < 80) a = trnr_pkg::ACT_MAP;
			else if (r < 88) a = trnr_pkg::ACT_DEFAULT;
			else if (r < 96) a = trnr_pkg::ACT_INIT;
			else a = 3'($urandom_range(6, 7));
			// mostly a small pin and node pool so drivers collide
			send_request(a,
				($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
				($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
				2'($urandom));
		end
		send_request(trnr_pkg::ACT_STEP, 0, 0, 0);
	endtask

	initial begin
		errors = 0;
		sink_stall_on = 0;
		now_step = 1;
		for (int i = 0; i < 256; i++) begin
			pin_map[i] = 0;
			pin_lv[i] = trnr_pkg::LV_UNDEF;
			pin_drv[i] = 0;
		end
		for (int i = 0; i < 64; i++) begin
			drv_cnt[i] = 0;
			drv_xor[i] = 0;
			node_dflt[i] = trnr_pkg::LV_UNDEF;
			node_pend[i] = trnr_pkg::LV_FALSE;
			node_set[i] = trnr_pkg::LV_FALSE;
			node_ctime[i] = 0;
			node_mark[i] = 0;
		end
		req.valid = 1'b0;
		req.action = '0;
		req.pin = '0;
		req.node = '0;
		req.level = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		sink_stall_on = 1;
		test_random();
		drain_expected();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("[tristate_net_resolver_top] OK");
		else
			$display("[tristate_net_resolver_top] ERROR");
		$finish;
	end

endmodule
